/* sv/frhm_pkg.sv */
// ----------------------------------------------------------------------------
// frhm_pkg: shared types and constants of the frame rate and heap meter
// Sequencer states, divider sizes and the fixed scale factors of the outputs.
// ----------------------------------------------------------------------------
package frhm_pkg;

    localparam logic [15:0] WINDOW_RESET = 16'd250;
    localparam int unsigned MS_PER_SEC   = 1000;
    localparam int unsigned KB_HALF      = 512;
    localparam int unsigned KB_SHIFT     = 10;     // 1024 bytes per kilobyte
    localparam int unsigned PCT_FULL     = 100;

    // quotient bits produced by the divider for each result; a larger
    // quotient is caught by the up-front check and saturated
    localparam int unsigned RATE_QBITS   = 16;
    localparam int unsigned PCT_QBITS    = 7;

    localparam int unsigned DVD_W        = 43;     // frames*1000 + sum/2
    localparam int unsigned DIV_W        = 32;
    localparam int unsigned REM_W        = DIV_W + 1;
    localparam int unsigned CNT_W        = $clog2(RATE_QBITS + 1);

    localparam logic [15:0] FPS_MAX      = 16'hFFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_CMP,
        S_LOAD,
        S_CHK,
        S_DIV,
        S_PSET,
        S_EMIT
    } state_t;

endpackage

/* sv/frame_rate_and_heap_meter.sv */
// ----------------------------------------------------------------------------
// frame_rate_and_heap_meter
// Window based frame rate and heap usage meter with a shared serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one frame tick per beat:
//   now_ms, heap_used, heap_total, heap_reserve. in_stall is high while a
//   tick is being processed; one tick is taken at a time.
//   A tick that closes a window yields one output beat (out_valid /
//   out_stall) with frames_per_second, heap_kilobytes and heap_percent.
//   Other ticks yield nothing and free the input once the sequencer is back
//   in idle. A closing tick runs through accumulate and compare, then one
//   compare/subtract unit runs a 16-step quotient for the rate, then a 7-step
//   quotient for the percentage, each preceded by an overflow check that
//   skips its steps when it saturates; the next tick is taken after emit.
//   The result sits in an output register; while the receiver stalls, the
//   next closing tick waits in its last step until the register is free.
//   cfg_valid / cfg_ready writes window_ms (cfg_ready is always high); write
//   it only while the block is idle. A window of zero behaves as one.
//   Reset clears the stored timestamp, the accumulator and the frame count,
//   sets window_ms to 250 and drops out_valid.
// ----------------------------------------------------------------------------
module frame_rate_and_heap_meter (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] now_ms,
    input  logic [23:0] heap_used,
    input  logic [23:0] heap_total,
    input  logic [23:0] heap_reserve,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] frames_per_second,
    output logic [14:0] heap_kilobytes,
    output logic [6:0]  heap_percent
);

    localparam int unsigned DVD_W = frhm_pkg::DVD_W;
    localparam int unsigned DIV_W = frhm_pkg::DIV_W;
    localparam int unsigned REM_W = frhm_pkg::REM_W;
    localparam int unsigned CNT_W = frhm_pkg::CNT_W;
    localparam int unsigned RQ    = frhm_pkg::RATE_QBITS;
    localparam int unsigned PQ    = frhm_pkg::PCT_QBITS;

    frhm_pkg::state_t state_reg, state_next;

    logic [15:0]      window_reg;
    logic [31:0]      last_time_reg, last_time_next;
    logic [31:0]      elapsed_reg, elapsed_next;
    logic [31:0]      frames_reg, frames_next;

    logic [31:0]      now_reg;
    logic [23:0]      used_reg, budget_reg, reserve_reg;

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DIV_W-1:0] div_reg, div_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [RQ-1:0]    q_reg, q_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pct_phase_reg, pct_phase_next;
    logic [23:0]      limit_reg, limit_next;
    logic [14:0]      kb_reg, kb_next;
    logic [15:0]      fps_reg, fps_next;
    logic [6:0]       pct_reg, pct_next;

    logic             out_valid_reg, out_valid_next;
    logic [15:0]      fps_out_reg, fps_out_next;
    logic [14:0]      kb_out_reg, kb_out_next;
    logic [6:0]       pct_out_reg, pct_out_next;

    // shared compare/subtract unit
    logic [REM_W-1:0] unit_a;
    logic [REM_W-1:0] unit_diff;
    logic             unit_ge;

    logic [31:0]      win;
    logic [31:0]      dt;
    logic [32:0]      sum_wide;
    logic [24:0]      kb_sum;
    logic             accept;
    logic             out_free;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign win      = (window_reg == 16'd0) ? 32'd1 : {16'd0, window_reg};
    assign dt       = now_reg - last_time_reg;
    assign sum_wide = {1'b0, elapsed_reg} + {1'b0, dt};
    assign kb_sum   = {1'b0, used_reg} + 25'(frhm_pkg::KB_HALF);

    assign unit_a    = (state_reg == frhm_pkg::S_CHK) ? rem_reg
                                                      : {rem_reg[REM_W-2:0], q_reg[RQ-1]};
    assign unit_ge   = unit_a >= {1'b0, div_reg};
    assign unit_diff = unit_a - {1'b0, div_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            frhm_pkg::S_IDLE:
            begin
                if (accept)
                    state_next = frhm_pkg::S_ACC;
            end
            frhm_pkg::S_ACC:
            begin
                if (last_time_reg == 32'd0)
                    state_next = frhm_pkg::S_IDLE;
                else
                    state_next = frhm_pkg::S_CMP;
            end
            frhm_pkg::S_CMP:
            begin
                if (elapsed_reg < win)
                    state_next = frhm_pkg::S_IDLE;
                else
                    state_next = frhm_pkg::S_LOAD;
            end
            frhm_pkg::S_LOAD:
            begin
                state_next = frhm_pkg::S_CHK;
            end
            frhm_pkg::S_CHK:
            begin
                if (!unit_ge)
                    state_next = frhm_pkg::S_DIV;
                else if (pct_phase_reg)
                    state_next = frhm_pkg::S_EMIT;
                else
                    state_next = frhm_pkg::S_PSET;
            end
            frhm_pkg::S_DIV:
            begin
                if (cnt_reg == CNT_W'(1))
                    state_next = pct_phase_reg ? frhm_pkg::S_EMIT : frhm_pkg::S_PSET;
            end
            frhm_pkg::S_PSET:
            begin
                state_next = frhm_pkg::S_LOAD;
            end
            frhm_pkg::S_EMIT:
            begin
                if (out_free)
                    state_next = frhm_pkg::S_IDLE;
            end
            default:
            begin
                state_next = frhm_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        last_time_next = last_time_reg;
        elapsed_next   = elapsed_reg;
        frames_next    = frames_reg;
        dvd_next       = dvd_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;
        pct_phase_next = pct_phase_reg;
        limit_next     = limit_reg;
        kb_next        = kb_reg;
        fps_next       = fps_reg;
        pct_next       = pct_reg;
        out_valid_next = out_valid_reg && out_stall;
        fps_out_next   = fps_out_reg;
        kb_out_next    = kb_out_reg;
        pct_out_next   = pct_out_reg;

        case (state_reg)
            frhm_pkg::S_ACC:
            begin
                last_time_next = now_reg;
                if (last_time_reg != 32'd0)
                begin
                    elapsed_next = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
                    if (frames_reg != 32'hFFFF_FFFF)
                        frames_next = frames_reg + 32'd1;
                end
            end
            frhm_pkg::S_CMP:
            begin
                if (elapsed_reg >= win)
                begin
                    dvd_next = DVD_W'(frames_reg) * DVD_W'(frhm_pkg::MS_PER_SEC)
                             + DVD_W'(elapsed_reg >> 1);
                    div_next       = elapsed_reg;
                    kb_next        = 15'(kb_sum >> frhm_pkg::KB_SHIFT);
                    limit_next     = (budget_reg > reserve_reg) ? (budget_reg - reserve_reg)
                                                                : 24'd1;
                    pct_phase_next = 1'b0;
                    elapsed_next   = 32'd0;
                    frames_next    = 32'd0;
                end
            end
            frhm_pkg::S_LOAD:
            begin
                if (pct_phase_reg)
                begin
                    rem_next = REM_W'(dvd_reg >> PQ);
                    q_next   = {dvd_reg[PQ-1:0], (RQ-PQ)'(0)};
                    cnt_next = CNT_W'(PQ);
                end
                else
                begin
                    rem_next = REM_W'(dvd_reg >> RQ);
                    q_next   = dvd_reg[RQ-1:0];
                    cnt_next = CNT_W'(RQ);
                end
            end
            frhm_pkg::S_CHK:
            begin
                // high part already >= divisor: quotient overflows its field
                if (unit_ge)
                begin
                    if (pct_phase_reg)
                        pct_next = 7'(frhm_pkg::PCT_FULL);
                    else
                        fps_next = frhm_pkg::FPS_MAX;
                end
            end
            frhm_pkg::S_DIV:
            begin
                rem_next = unit_ge ? unit_diff : unit_a;
                q_next   = {q_reg[RQ-2:0], unit_ge};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    if (pct_phase_reg)
                        pct_next = (q_next[PQ-1:0] > 7'(frhm_pkg::PCT_FULL))
                                 ? 7'(frhm_pkg::PCT_FULL) : q_next[PQ-1:0];
                    else
                        fps_next = q_next;
                end
            end
            frhm_pkg::S_PSET:
            begin
                dvd_next = DVD_W'(32'(used_reg) * 32'(frhm_pkg::PCT_FULL)
                                  + 32'(limit_reg >> 1));
                div_next       = DIV_W'(limit_reg);
                pct_phase_next = 1'b1;
            end
            frhm_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    fps_out_next   = fps_reg;
                    kb_out_next    = kb_reg;
                    pct_out_next   = pct_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= frhm_pkg::S_IDLE;
            window_reg    <= frhm_pkg::WINDOW_RESET;
            last_time_reg <= 32'd0;
            elapsed_reg   <= 32'd0;
            frames_reg    <= 32'd0;
            cnt_reg       <= '0;
            pct_phase_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_valid && cfg_ready)
                window_reg <= cfg_data;
            last_time_reg <= last_time_next;
            elapsed_reg   <= elapsed_next;
            frames_reg    <= frames_next;
            cnt_reg       <= cnt_next;
            pct_phase_reg <= pct_phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg     <= now_ms;
            used_reg    <= heap_used;
            budget_reg  <= heap_total;
            reserve_reg <= heap_reserve;
        end
        dvd_reg     <= dvd_next;
        div_reg     <= div_next;
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        limit_reg   <= limit_next;
        kb_reg      <= kb_next;
        fps_reg     <= fps_next;
        pct_reg     <= pct_next;
        fps_out_reg <= fps_out_next;
        kb_out_reg  <= kb_out_next;
        pct_out_reg <= pct_out_next;
    end

    assign cfg_ready         = 1'b1;
    assign in_stall          = (state_reg != frhm_pkg::S_IDLE);
    assign out_valid         = out_valid_reg;
    assign frames_per_second = fps_out_reg;
    assign heap_kilobytes    = kb_out_reg;
    assign heap_percent      = pct_out_reg;

    // restoring divider: partial remainder always below the divisor
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == frhm_pkg::S_DIV) |-> (rem_reg < {1'b0, div_reg}))
        else $error("partial remainder not below divisor");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == frhm_pkg::S_DIV || state_reg == frhm_pkg::S_CHK) |-> (div_reg != '0))
        else $error("divider running with zero divisor");

    a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == frhm_pkg::S_DIV) |-> (cnt_reg != '0))
        else $error("divider step count exhausted");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (pct_out_reg <= 7'(frhm_pkg::PCT_FULL)))
        else $error("heap percent above full scale");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == frhm_pkg::S_EMIT && out_free) |=> out_valid_reg)
        else $error("result not presented after emit");

endmodule
